>>> rtl/apa_pkg.sv
// shared types, codes and defaults for the alarm priority annunciator
package apa_pkg;

   localparam int ALARM_COUNT_DEFAULT  = 8;
   localparam int HIGH_SLOTS_DEFAULT   = 4;
   localparam int MEDIUM_SLOTS_DEFAULT = 4;

   localparam int KIND_W      = 2;
   localparam int INDEX_W     = 3;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;
   localparam int COUNT_W     = 8;
   localparam int TICKS_W     = 16;

   typedef enum logic [KIND_W-1:0] {
      KIND_TICK   = 2'd0,
      KIND_COND   = 2'd1,
      KIND_CLEAR  = 2'd2,
      KIND_TOGGLE = 2'd3
   } kind_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_ALARM_LEVELS        = 3'd0,
      REG_ALARM_CLEARABLE     = 3'd1,
      REG_CLEAR_COUNTS        = 3'd2,
      REG_HIGH_DURATIONS      = 3'd3,
      REG_MEDIUM_DURATIONS    = 3'd4,
      REG_HIGH_PATTERN_BITS   = 3'd5,
      REG_MEDIUM_PATTERN_BITS = 3'd6
   } csr_reg_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_FINISH
   } apa_state_type;

   typedef struct packed {
      logic [15:0] levels;
      logic [7:0]  clearable;
      logic [63:0] clear_counts;
      logic [63:0] high_durations;
      logic [63:0] medium_durations;
      logic [3:0]  high_bits;
      logic [3:0]  medium_bits;
      logic        reload;
   } apa_cfg_type;

   typedef struct packed {
      logic take;
      logic apply;
      logic scan_clr;
      logic scan_inc;
      logic hit;
      logic no_alarm;
      logic emit;
   } apa_cmd_type;

   typedef struct packed {
      logic is_tick;
      logic disabled;
      logic hit;
      logic scan_last;
      logic out_free;
   } apa_status_type;

endpackage

>>> rtl/apa_csr.sv
// configuration register file with count reload strobe
module apa_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [apa_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [apa_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output apa_pkg::apa_cfg_type                cfg
);

   apa_pkg::apa_cfg_type cfg_ff, cfg_in;
   logic                 write;

   assign csr_ready = 1'b1;
   assign write     = csr_valid && csr_ready;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in        = cfg_ff;
      cfg_in.reload = 1'b0;
      if (write) begin
         case (csr_index)
            apa_pkg::REG_ALARM_LEVELS:        cfg_in.levels = csr_wdata[15:0];
            apa_pkg::REG_ALARM_CLEARABLE:     cfg_in.clearable = csr_wdata[7:0];
            apa_pkg::REG_CLEAR_COUNTS: begin
               cfg_in.clear_counts = csr_wdata;
               cfg_in.reload       = 1'b1;
            end
            apa_pkg::REG_HIGH_DURATIONS:      cfg_in.high_durations = csr_wdata;
            apa_pkg::REG_MEDIUM_DURATIONS:    cfg_in.medium_durations = csr_wdata;
            apa_pkg::REG_HIGH_PATTERN_BITS:   cfg_in.high_bits = csr_wdata[3:0];
            apa_pkg::REG_MEDIUM_PATTERN_BITS: cfg_in.medium_bits = csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> rtl/apa_datapath.sv
// alarm lanes, serial scan pointer, pattern timer and output word register
module apa_datapath #(
   parameter int ALARM_COUNT  = apa_pkg::ALARM_COUNT_DEFAULT,
   parameter int HIGH_SLOTS   = apa_pkg::HIGH_SLOTS_DEFAULT,
   parameter int MEDIUM_SLOTS = apa_pkg::MEDIUM_SLOTS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  apa_pkg::apa_cmd_type            cmd,
   output apa_pkg::apa_status_type         status,
   input  apa_pkg::apa_cfg_type            cfg,
   input  logic [apa_pkg::KIND_W-1:0]      req_kind,
   input  logic [apa_pkg::INDEX_W-1:0]     req_alarm_index,
   input  logic                            req_condition_on,
   input  logic                            rsp_ready,
   output logic                            rsp_valid,
   output logic                            rsp_sound_on,
   output logic                            rsp_alarm_present,
   output logic [2:0]                      rsp_shown_alarm,
   output logic [1:0]                      rsp_shown_level,
   output logic                            rsp_alarms_enabled
);

   localparam int SCAN_W = (ALARM_COUNT > 1) ? $clog2(ALARM_COUNT) : 1;
   localparam logic [2:0] HIGH_SLOTS_N   = 3'(HIGH_SLOTS);
   localparam logic [2:0] MEDIUM_SLOTS_N = 3'(MEDIUM_SLOTS);
   localparam logic [SCAN_W-1:0] SCAN_LAST = SCAN_W'(ALARM_COUNT - 1);

   // latched request word
   apa_pkg::kind_type              op_kind_ff;
   logic [apa_pkg::INDEX_W-1:0]    op_idx_ff;
   logic                           op_on_ff;

   // alarm lanes
   logic                           alarm_on_ff [ALARM_COUNT];
   logic                           alarm_on_in [ALARM_COUNT];
   logic [apa_pkg::COUNT_W-1:0]    clear_left_ff [ALARM_COUNT];
   logic [apa_pkg::COUNT_W-1:0]    clear_left_in [ALARM_COUNT];
   logic [1:0]                     lane_level [ALARM_COUNT];
   logic [ALARM_COUNT-1:0]         active;

   logic [SCAN_W-1:0]              scan_ff, scan_in;
   logic [3:0]                     scan_ext;

   // pattern and choice state
   logic                           disabled_ff, disabled_in;
   logic                           entering_ff, entering_in;
   logic [1:0]                     interval_ff, interval_in;
   logic [apa_pkg::TICKS_W-1:0]    elapsed_ff, elapsed_in;
   logic                           sound_ff, sound_in;
   logic                           present_ff, present_in;
   logic [2:0]                     chosen_ff, chosen_in;
   logic [1:0]                     level_ff, level_in;

   // output word
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_sound_ff;
   logic                           rsp_present_ff;
   logic [2:0]                     rsp_alarm_ff;
   logic [1:0]                     rsp_level_ff;
   logic                           rsp_enabled_ff;

   // pattern step
   logic [1:0]                     lvl;
   logic                           lvl_ok;
   logic                           is_high;
   logic [63:0]                    durs;
   logic [3:0]                     pbits;
   logic [2:0]                     slots;
   logic [apa_pkg::TICKS_W-1:0]    elapsed_step;
   logic [apa_pkg::TICKS_W-1:0]    dur;
   logic [2:0]                     next_idx_wide;
   logic [1:0]                     next_idx;
   logic                           is_clear;

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         op_kind_ff <= apa_pkg::kind_type'(req_kind);
         op_idx_ff  <= req_alarm_index;
         op_on_ff   <= req_condition_on;
      end
   end

   genvar gi;
   generate
      for (gi = 0; gi < ALARM_COUNT; gi++) begin : g_lane
         logic [apa_pkg::COUNT_W-1:0] lane_init;
         logic                        lane_clearable;
         logic                        lane_sel;

         if (gi < 8) begin : g_mapped
            assign lane_init      = cfg.clear_counts[8*gi +: 8];
            assign lane_clearable = cfg.clearable[gi];
            assign lane_level[gi] = cfg.levels[2*gi +: 2];
         end else begin : g_unmapped
            assign lane_init      = '0;
            assign lane_clearable = 1'b0;
            assign lane_level[gi] = 2'd0;
         end

         assign lane_sel   = ({1'b0, op_idx_ff} == 4'(gi));
         assign active[gi] = alarm_on_ff[gi] && (clear_left_ff[gi] != '0);

         always_comb begin
            alarm_on_in[gi]   = alarm_on_ff[gi];
            clear_left_in[gi] = clear_left_ff[gi];
            if (cfg.reload) begin
               clear_left_in[gi] = lane_init;
            end
            if (cmd.apply) begin
               case (op_kind_ff)
                  apa_pkg::KIND_COND: begin
                     if (lane_sel) begin
                        if (op_on_ff) begin
                           alarm_on_in[gi]   = 1'b1;
                           clear_left_in[gi] = lane_init;
                        end else begin
                           alarm_on_in[gi] = 1'b0;
                           if (lane_clearable && (clear_left_ff[gi] != '0)) begin
                              clear_left_in[gi] = clear_left_ff[gi] - 1'b1;
                           end
                        end
                     end
                  end
                  apa_pkg::KIND_CLEAR: begin
                     alarm_on_in[gi]   = 1'b0;
                     clear_left_in[gi] = lane_init;
                  end
                  default: ;
               endcase
            end
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < ALARM_COUNT; k++) begin
            alarm_on_ff[k]   <= 1'b0;
            clear_left_ff[k] <= '0;
         end
      end else begin
         for (int k = 0; k < ALARM_COUNT; k++) begin
            alarm_on_ff[k]   <= alarm_on_in[k];
            clear_left_ff[k] <= clear_left_in[k];
         end
      end
   end

   // scan pointer
   always_comb begin
      scan_in = scan_ff;
      if (cmd.scan_clr) begin
         scan_in = '0;
      end else if (cmd.scan_inc) begin
         scan_in = scan_ff + 1'b1;
      end
   end

   assign scan_ext = 4'(scan_ff);

   // pattern step for the alarm under the scan pointer
   assign lvl           = lane_level[scan_ff];
   assign lvl_ok        = (lvl == 2'd1) || (lvl == 2'd2);
   assign is_high       = (lvl == 2'd2);
   assign durs          = is_high ? cfg.high_durations : cfg.medium_durations;
   assign pbits         = is_high ? cfg.high_bits : cfg.medium_bits;
   assign slots         = is_high ? HIGH_SLOTS_N : MEDIUM_SLOTS_N;
   assign elapsed_step  = entering_ff ? '0 :
                          (elapsed_ff != '1) ? elapsed_ff + 1'b1 : elapsed_ff;
   assign dur           = durs[{interval_ff, 4'b0000} +: 16];
   assign next_idx_wide = {1'b0, interval_ff} + 3'd1;
   assign next_idx      = (next_idx_wide >= slots) ? 2'd0 : next_idx_wide[1:0];
   assign is_clear      = cmd.apply && (op_kind_ff == apa_pkg::KIND_CLEAR);

   always_comb begin
      disabled_in = disabled_ff;
      entering_in = entering_ff;
      interval_in = interval_ff;
      elapsed_in  = elapsed_ff;
      sound_in    = sound_ff;
      present_in  = present_ff;
      chosen_in   = chosen_ff;
      level_in    = level_ff;

      if (cmd.apply && (op_kind_ff == apa_pkg::KIND_TOGGLE)) begin
         disabled_in = !disabled_ff;
      end

      if (cmd.no_alarm || (cmd.hit && !lvl_ok) || is_clear) begin
         sound_in    = 1'b0;
         interval_in = 2'd0;
         entering_in = 1'b1;
      end else if (cmd.hit) begin
         entering_in = 1'b0;
         elapsed_in  = elapsed_step;
         if (elapsed_step >= dur) begin
            interval_in = next_idx;
            sound_in    = pbits[next_idx];
            elapsed_in  = '0;
         end
      end

      if (cmd.no_alarm || (cmd.hit && !lvl_ok)) begin
         present_in = 1'b0;
         chosen_in  = 3'd0;
         level_in   = 2'd0;
      end else if (cmd.hit) begin
         present_in = 1'b1;
         chosen_in  = scan_ext[2:0];
         level_in   = lvl;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff     <= '0;
         disabled_ff <= 1'b0;
         entering_ff <= 1'b1;
         interval_ff <= 2'd0;
         elapsed_ff  <= '0;
         sound_ff    <= 1'b0;
         present_ff  <= 1'b0;
         chosen_ff   <= 3'd0;
         level_ff    <= 2'd0;
      end else begin
         scan_ff     <= scan_in;
         disabled_ff <= disabled_in;
         entering_ff <= entering_in;
         interval_ff <= interval_in;
         elapsed_ff  <= elapsed_in;
         sound_ff    <= sound_in;
         present_ff  <= present_in;
         chosen_ff   <= chosen_in;
         level_ff    <= level_in;
      end
   end

   // output word register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_sound_ff   <= sound_ff;
         rsp_present_ff <= present_ff;
         rsp_alarm_ff   <= chosen_ff;
         rsp_level_ff   <= level_ff;
         rsp_enabled_ff <= !disabled_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_sound_on       = rsp_sound_ff;
   assign rsp_alarm_present  = rsp_present_ff;
   assign rsp_shown_alarm    = rsp_alarm_ff;
   assign rsp_shown_level    = rsp_level_ff;
   assign rsp_alarms_enabled = rsp_enabled_ff;

   assign status.is_tick   = (op_kind_ff == apa_pkg::KIND_TICK);
   assign status.disabled  = disabled_ff;
   assign status.hit       = active[scan_ff];
   assign status.scan_last = (scan_ff == SCAN_LAST);
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   a_emit_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_ready))
      else $error("word loaded into a full output register");

   a_clear_silences: assert property (@(posedge clock) disable iff (reset)
      is_clear |=> (!sound_ff && entering_ff && interval_ff == 2'd0))
      else $error("clear all left the pattern running");

   a_enter_restarts: assert property (@(posedge clock) disable iff (reset)
      (cmd.hit && entering_ff && (lvl == 2'd1 || lvl == 2'd2))
      |=> (elapsed_ff == '0 && !entering_ff))
      else $error("pattern entry did not restart the interval timer");

endmodule

>>> rtl/apa_ctrl.sv
// sequencing state machine: accept, execute, scan, hand off
module apa_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  apa_pkg::apa_status_type  status,
   output apa_pkg::apa_cmd_type     cmd
);

   apa_pkg::apa_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         apa_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = apa_pkg::ST_EXEC;
            end
         end
         apa_pkg::ST_EXEC: begin
            if (status.is_tick && !status.disabled) begin
               state_in = apa_pkg::ST_SCAN;
            end else begin
               state_in = apa_pkg::ST_FINISH;
            end
         end
         apa_pkg::ST_SCAN: begin
            if (status.hit || status.scan_last) begin
               state_in = apa_pkg::ST_FINISH;
            end
         end
         apa_pkg::ST_FINISH: begin
            if (status.out_free) begin
               state_in = apa_pkg::ST_IDLE;
            end
         end
         default: state_in = apa_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         apa_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.take  = req_valid;
         end
         apa_pkg::ST_EXEC: begin
            if (!status.is_tick) begin
               cmd.apply = 1'b1;
            end else if (status.disabled) begin
               cmd.no_alarm = 1'b1;
            end else begin
               cmd.scan_clr = 1'b1;
            end
         end
         apa_pkg::ST_SCAN: begin
            if (status.hit) begin
               cmd.hit = 1'b1;
            end else if (status.scan_last) begin
               cmd.no_alarm = 1'b1;
            end else begin
               cmd.scan_inc = 1'b1;
            end
         end
         apa_pkg::ST_FINISH: begin
            cmd.emit = status.out_free;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= apa_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_one_command: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.take, cmd.apply, cmd.scan_clr, cmd.scan_inc,
                cmd.hit, cmd.no_alarm, cmd.emit}))
      else $error("more than one datapath command in a cycle");

   a_scan_stops: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_inc |-> (!status.hit && !status.scan_last))
      else $error("scan moved past a hit or the last alarm");

   a_event_no_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == apa_pkg::ST_EXEC && !status.is_tick)
      |=> (state_ff == apa_pkg::ST_FINISH))
      else $error("non-tick word entered the scan");

endmodule

>>> rtl/alarm_priority_annunciator.sv
// alarm priority annunciator top level
//
// Input channel req_*: one word per event (tick, condition, clear all,
// toggle enable), valid/ready. Output channel rsp_*: exactly one word per
// input word, in order, carrying buzzer level, chosen alarm and enable.
// Configuration channel csr_*: index and 64-bit data, always ready; write
// only while no word is in flight.
// From input accept, condition, clear, toggle and disabled ticks pass
// through the execute and finish states; an enabled tick passes through
// execute, the scan that visits one alarm per cycle until the first hit
// or the last alarm, and finish. A new word is accepted the cycle after
// the previous result is loaded into the output register.
// Reset (synchronous, active high) clears the configuration and alarm
// state: all alarms off, counts zero, alarms enabled, pattern silent and
// restarted.
// A stalled rsp_ready holds the result in the output register; the next
// word is still accepted and waits for the register to free before its
// own result is loaded.
module alarm_priority_annunciator #(
   parameter int ALARM_COUNT  = apa_pkg::ALARM_COUNT_DEFAULT,
   parameter int HIGH_SLOTS   = apa_pkg::HIGH_SLOTS_DEFAULT,
   parameter int MEDIUM_SLOTS = apa_pkg::MEDIUM_SLOTS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [apa_pkg::KIND_W-1:0]       req_kind,
   input  logic [apa_pkg::INDEX_W-1:0]      req_alarm_index,
   input  logic                             req_condition_on,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_sound_on,
   output logic                             rsp_alarm_present,
   output logic [2:0]                       rsp_shown_alarm,
   output logic [1:0]                       rsp_shown_level,
   output logic                             rsp_alarms_enabled,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [apa_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [apa_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   apa_pkg::apa_cfg_type    cfg;
   apa_pkg::apa_cmd_type    cmd;
   apa_pkg::apa_status_type status;

   apa_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   apa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   apa_datapath #(
      .ALARM_COUNT  (ALARM_COUNT),
      .HIGH_SLOTS   (HIGH_SLOTS),
      .MEDIUM_SLOTS (MEDIUM_SLOTS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .cfg                (cfg),
      .req_kind           (req_kind),
      .req_alarm_index    (req_alarm_index),
      .req_condition_on   (req_condition_on),
      .rsp_ready          (rsp_ready),
      .rsp_valid          (rsp_valid),
      .rsp_sound_on       (rsp_sound_on),
      .rsp_alarm_present  (rsp_alarm_present),
      .rsp_shown_alarm    (rsp_shown_alarm),
      .rsp_shown_level    (rsp_shown_level),
      .rsp_alarms_enabled (rsp_alarms_enabled)
   );

endmodule

>>> verif/alarm_priority_annunciator_tb.sv
// testbench for the alarm priority annunciator: every response word checked against a predictor
`timescale 1ns / 100ps

module alarm_priority_annunciator_tb;
   import apa_pkg::*;

   localparam int ALARMS          = ALARM_COUNT_DEFAULT;
   localparam int SETTLE_CYCLES   = ALARMS + 4;
   localparam int CYCLE_LIMIT     = 600000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int PHASES          = 8;
   localparam int PHASE_WORDS     = 90;
   localparam int REPORT_LIMIT    = 10;

   localparam logic [CSR_INDEX_W-1:0] REG_SPARE = 3'd7;

   localparam logic [1:0] LEVEL_NONE    = 2'd0;
   localparam logic [1:0] LEVEL_HIGH    = 2'd2;
   localparam logic [1:0] LEVEL_INVALID = 2'd3;

   typedef struct packed {
      logic       sound;
      logic       present;
      logic [2:0] alarm;
      logic [1:0] level;
      logic       enabled;
   } annunciation_type;

   logic                   clock              = 1'b0;
   logic                   reset              = 1'b1;
   logic                   req_valid          = 1'b0;
   logic                   req_ready;
   logic [KIND_W-1:0]      req_kind           = '0;
   logic [INDEX_W-1:0]     req_alarm_index    = '0;
   logic                   req_condition_on   = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready          = 1'b0;
   logic                   rsp_sound_on;
   logic                   rsp_alarm_present;
   logic [2:0]             rsp_shown_alarm;
   logic [1:0]             rsp_shown_level;
   logic                   rsp_alarms_enabled;
   logic                   csr_valid          = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index          = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata          = '0;

   // predicted configuration
   logic [15:0] cfg_levels         = '0;
   logic [7:0]  cfg_clearable      = '0;
   logic [63:0] cfg_clear_counts   = '0;
   logic [63:0] cfg_high_durations = '0;
   logic [63:0] cfg_med_durations  = '0;
   logic [3:0]  cfg_high_bits      = '0;
   logic [3:0]  cfg_med_bits       = '0;

   // predicted alarm and pattern state
   logic        mdl_alarm_on   [ALARMS] = '{default: 1'b0};
   logic [7:0]  mdl_clear_left [ALARMS] = '{default: 8'd0};
   logic        mdl_disabled = 1'b0;
   logic        mdl_entering = 1'b1;
   logic [1:0]  mdl_slot     = '0;
   logic [15:0] mdl_elapsed  = '0;
   logic        mdl_sound    = 1'b0;
   logic [5:0]  mdl_choice   = '0;

   annunciation_type annunciation_q[$];
   int  fail_count   = 0;
   int  words_seen   = 0;
   int  cycle_count  = 0;
   bit  steady_tx    = 1'b0;
   bit  steady_rx    = 1'b0;
   bit  hold_request = 1'b0;

   alarm_priority_annunciator DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_kind           (req_kind),
      .req_alarm_index    (req_alarm_index),
      .req_condition_on   (req_condition_on),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_sound_on       (rsp_sound_on),
      .rsp_alarm_present  (rsp_alarm_present),
      .rsp_shown_alarm    (rsp_shown_alarm),
      .rsp_shown_level    (rsp_shown_level),
      .rsp_alarms_enabled (rsp_alarms_enabled),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("** alarm_priority_annunciator: FAILED **");
         $finish;
      end
   end

   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic void reload_clear_counts();
      for (int i = 0; i < ALARMS; i++)
         mdl_clear_left[i] = cfg_clear_counts[8*i +: 8];
   endfunction

   function automatic void restart_pattern();
      mdl_sound    = 1'b0;
      mdl_slot     = '0;
      mdl_entering = 1'b1;
   endfunction

   function automatic annunciation_type predict_annunciation(kind_type kind, logic [2:0] idx,
                                                             logic on);
      annunciation_type word;
      logic             found;
      logic [1:0]       lvl;
      logic [2:0]       pick;
      logic [63:0]      durs;
      logic [3:0]       bits;
      logic [1:0]       slot;
      found = 1'b0;
      lvl   = LEVEL_NONE;
      pick  = '0;
      case (kind)
         KIND_TICK: begin
            if (!mdl_disabled) begin
               for (int i = 0; i < ALARMS; i++) begin
                  if (!found && mdl_alarm_on[i] && mdl_clear_left[i] != 8'd0) begin
                     found = 1'b1;
                     lvl   = cfg_levels[2*i +: 2];
                     pick  = 3'(i);
                  end
               end
            end
            if (!found || lvl == LEVEL_NONE || lvl == LEVEL_INVALID) begin
               restart_pattern();
               mdl_choice = '0;
            end else begin
               durs = (lvl == LEVEL_HIGH) ? cfg_high_durations : cfg_med_durations;
               bits = (lvl == LEVEL_HIGH) ? cfg_high_bits : cfg_med_bits;
               slot = mdl_slot;
               if (mdl_entering) begin
                  mdl_elapsed  = '0;
                  mdl_entering = 1'b0;
               end else if (mdl_elapsed != 16'hFFFF) begin
                  mdl_elapsed = mdl_elapsed + 16'd1;
               end
               if (mdl_elapsed >= durs[16*slot +: 16]) begin
                  // four slots per priority, so the index wraps by itself
                  slot        = slot + 2'd1;
                  mdl_slot    = slot;
                  mdl_sound   = bits[slot];
                  mdl_elapsed = '0;
               end
               mdl_choice = {1'b1, pick, lvl};
            end
         end
         KIND_COND: begin
            if (on) begin
               mdl_alarm_on[idx]   = 1'b1;
               mdl_clear_left[idx] = cfg_clear_counts[8*idx +: 8];
            end else begin
               mdl_alarm_on[idx] = 1'b0;
               if (cfg_clearable[idx] && mdl_clear_left[idx] != 8'd0)
                  mdl_clear_left[idx] = mdl_clear_left[idx] - 8'd1;
            end
         end
         KIND_CLEAR: begin
            for (int i = 0; i < ALARMS; i++)
               mdl_alarm_on[i] = 1'b0;
            reload_clear_counts();
            restart_pattern();
         end
         default: begin
            mdl_disabled = !mdl_disabled;
         end
      endcase
      word.sound   = mdl_sound;
      word.present = mdl_choice[5];
      word.alarm   = mdl_choice[4:2];
      word.level   = mdl_choice[1:0];
      word.enabled = !mdl_disabled;
      return word;
   endfunction

   task automatic send_event(kind_type kind, logic [2:0] idx, logic on);
      int gap;
      gap = (steady_tx || $urandom_range(0, 99) < 50) ? 0 : idle_length();
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_kind         <= kind;
      req_alarm_index  <= idx;
      req_condition_on <= on;
      do @(posedge clock); while (!req_ready);
      annunciation_q.push_back(predict_annunciation(kind, idx, on));
   endtask

   task automatic random_event();
      int       r;
      kind_type kind;
      r = $urandom_range(0, 99);
      if (r < 45)
         kind = KIND_TICK;
      else if (r < 88)
         kind = KIND_COND;
      else if (r < (mdl_disabled ? 80 : 97) || r < 92)
         kind = (r < 92) ? KIND_CLEAR : KIND_TOGGLE;
      else
         kind = mdl_disabled ? KIND_CLEAR : KIND_TOGGLE;
      if (mdl_disabled && r >= 45 && r < 70)
         kind = KIND_TOGGLE;
      send_event(kind, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
   endtask

   task automatic csr_write(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_ALARM_LEVELS:        cfg_levels = data[15:0];
         REG_ALARM_CLEARABLE:     cfg_clearable = data[7:0];
         REG_CLEAR_COUNTS: begin
            cfg_clear_counts = data;
            reload_clear_counts();
         end
         REG_HIGH_DURATIONS:      cfg_high_durations = data;
         REG_MEDIUM_DURATIONS:    cfg_med_durations = data;
         REG_HIGH_PATTERN_BITS:   cfg_high_bits = data[3:0];
         REG_MEDIUM_PATTERN_BITS: cfg_med_bits = data[3:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle(int settle);
      @(negedge clock);
      req_valid <= 1'b0;
      while (annunciation_q.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_random_config();
      logic [63:0] counts;
      logic [63:0] hdur;
      logic [63:0] mdur;
      int          r;
      for (int i = 0; i < ALARMS; i++) begin
         r = $urandom_range(0, 99);
         counts[8*i +: 8] = (r < 15) ? 8'd0 : (r < 25) ? 8'hFF : 8'($urandom_range(1, 4));
      end
      for (int s = 0; s < 4; s++) begin
         r = $urandom_range(0, 99);
         hdur[16*s +: 16] = (r < 10) ? 16'd0 : (r < 14) ? 16'hFFFF : 16'($urandom_range(1, 6));
         r = $urandom_range(0, 99);
         mdur[16*s +: 16] = (r < 10) ? 16'd0 : (r < 14) ? 16'hFFFF : 16'($urandom_range(1, 6));
      end
      csr_write(REG_ALARM_LEVELS, 64'($urandom()));
      csr_write(REG_ALARM_CLEARABLE, 64'($urandom()));
      csr_write(REG_CLEAR_COUNTS, counts);
      csr_write(REG_HIGH_DURATIONS, hdur);
      csr_write(REG_MEDIUM_DURATIONS, mdur);
      csr_write(REG_HIGH_PATTERN_BITS, 64'($urandom()));
      csr_write(REG_MEDIUM_PATTERN_BITS, 64'($urandom()));
   endtask

   task automatic test_reset_state();
      send_event(KIND_TICK, 3'd0, 1'b0);
      send_event(KIND_COND, 3'd5, 1'b1);
      send_event(KIND_TICK, 3'd7, 1'b1);
      send_event(KIND_TOGGLE, 3'd0, 1'b0);
      send_event(KIND_TICK, 3'd0, 1'b0);
      send_event(KIND_TOGGLE, 3'd0, 1'b0);
      wait_idle(SETTLE_CYCLES);
   endtask

   task automatic test_register_extremes();
      csr_write(REG_ALARM_LEVELS, '1);
      csr_write(REG_ALARM_CLEARABLE, '1);
      csr_write(REG_CLEAR_COUNTS, '1);
      csr_write(REG_HIGH_DURATIONS, '1);
      csr_write(REG_MEDIUM_DURATIONS, '1);
      csr_write(REG_HIGH_PATTERN_BITS, '1);
      csr_write(REG_MEDIUM_PATTERN_BITS, '1);
      csr_write(REG_SPARE, '1);
      // every level is the invalid code, so a tick finds nothing to show
      send_event(KIND_COND, 3'd0, 1'b1);
      send_event(KIND_TICK, 3'd0, 1'b0);
      send_event(KIND_COND, 3'd0, 1'b0);
      send_event(KIND_TICK, 3'd0, 1'b0);
      wait_idle(SETTLE_CYCLES);
      csr_write(REG_ALARM_LEVELS, '0);
      csr_write(REG_ALARM_CLEARABLE, '0);
      csr_write(REG_CLEAR_COUNTS, '0);
      csr_write(REG_HIGH_DURATIONS, '0);
      csr_write(REG_MEDIUM_DURATIONS, '0);
      csr_write(REG_HIGH_PATTERN_BITS, '0);
      csr_write(REG_MEDIUM_PATTERN_BITS, '0);
   endtask

   task automatic test_priority_choice();
      csr_write(REG_ALARM_LEVELS, 64'h8236);
      csr_write(REG_ALARM_CLEARABLE, 64'h03);
      csr_write(REG_CLEAR_COUNTS, 64'hFF00_0000_0503_0201);
      csr_write(REG_HIGH_PATTERN_BITS, 64'h5);
      csr_write(REG_MEDIUM_PATTERN_BITS, 64'h3);
      send_event(KIND_COND, 3'd7, 1'b1);
      send_event(KIND_TICK, 3'd0, 1'b0);
      send_event(KIND_COND, 3'd4, 1'b1);
      send_event(KIND_TICK, 3'd0, 1'b0);
      send_event(KIND_COND, 3'd3, 1'b1);
      send_event(KIND_TICK, 3'd0, 1'b0);
      send_event(KIND_COND, 3'd3, 1'b0);
      send_event(KIND_COND, 3'd0, 1'b1);
      send_event(KIND_TICK, 3'd0, 1'b0);
      // clearable alarm counted down to zero drops out of the scan
      send_event(KIND_COND, 3'd0, 1'b0);
      send_event(KIND_COND, 3'd0, 1'b0);
      send_event(KIND_TICK, 3'd0, 1'b0);
      send_event(KIND_COND, 3'd2, 1'b1);
      send_event(KIND_TICK, 3'd0, 1'b0);
      send_event(KIND_COND, 3'd2, 1'b0);
      send_event(KIND_COND, 3'd1, 1'b1);
      send_event(KIND_TICK, 3'd0, 1'b0);
      send_event(KIND_CLEAR, 3'd0, 1'b0);
      send_event(KIND_TICK, 3'd0, 1'b0);
      send_event(KIND_TOGGLE, 3'd0, 1'b0);
      send_event(KIND_COND, 3'd7, 1'b1);
      send_event(KIND_TICK, 3'd0, 1'b0);
      send_event(KIND_TOGGLE, 3'd0, 1'b0);
      send_event(KIND_TICK, 3'd0, 1'b0);
      wait_idle(SETTLE_CYCLES);
   endtask

   task automatic test_pattern_timing();
      csr_write(REG_ALARM_LEVELS, 64'h0006);
      csr_write(REG_ALARM_CLEARABLE, 64'h00);
      csr_write(REG_CLEAR_COUNTS, 64'h0505);
      csr_write(REG_HIGH_DURATIONS, 64'h0003_0000_0002_0001);
      csr_write(REG_MEDIUM_DURATIONS, 64'h0001_0004_0000_0002);
      csr_write(REG_HIGH_PATTERN_BITS, 64'hA);
      csr_write(REG_MEDIUM_PATTERN_BITS, 64'h6);
      send_event(KIND_COND, 3'd1, 1'b1);
      repeat (8) send_event(KIND_TICK, 3'd0, 1'b0);
      // switch to high priority in the middle of the medium pattern
      send_event(KIND_COND, 3'd0, 1'b1);
      repeat (8) send_event(KIND_TICK, 3'd0, 1'b0);
      send_event(KIND_COND, 3'd0, 1'b0);
      repeat (4) send_event(KIND_TICK, 3'd0, 1'b0);
      send_event(KIND_CLEAR, 3'd0, 1'b0);
      repeat (2) send_event(KIND_TICK, 3'd0, 1'b0);
      wait_idle(SETTLE_CYCLES);
      csr_write(REG_HIGH_DURATIONS, '1);
      send_event(KIND_COND, 3'd0, 1'b1);
      repeat (3) send_event(KIND_TICK, 3'd0, 1'b0);
      wait_idle(SETTLE_CYCLES);
   endtask

   task automatic test_output_hold_off();
      write_random_config();
      hold_request = 1'b1;
      steady_tx    = 1'b1;
      repeat (40) random_event();
      steady_tx = 1'b0;
      wait_idle(SETTLE_CYCLES);
   endtask

   task automatic test_input_drain_pause();
      repeat (3) begin
         repeat (8) random_event();
         wait_idle(0);
      end
      wait_idle(SETTLE_CYCLES);
   endtask

   task automatic test_random_phases();
      for (int p = 0; p < PHASES; p++) begin
         write_random_config();
         steady_tx = (p == 0) || ($urandom_range(0, 3) == 0);
         steady_rx = (p == 0) || ($urandom_range(0, 3) == 0);
         repeat (PHASE_WORDS) random_event();
         wait_idle(SETTLE_CYCLES);
      end
      steady_tx = 1'b0;
      steady_rx = 1'b0;
   endtask

   initial begin
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left  = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_left    = HOLD_OFF_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left != 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (stall_left != 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else if (steady_rx || $urandom_range(0, 99) < 70) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b0;
            stall_left = idle_length() - 1;
         end
      end
   end

   always @(posedge clock) begin
      annunciation_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (annunciation_q.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
               $display("word %0d unexpected: sound %0b present %0b alarm %0d level %0d en %0b",
                        words_seen, rsp_sound_on, rsp_alarm_present, rsp_shown_alarm,
                        rsp_shown_level, rsp_alarms_enabled);
         end else begin
            want = annunciation_q.pop_front();
            if (rsp_sound_on !== want.sound || rsp_alarm_present !== want.present ||
                rsp_shown_alarm !== want.alarm || rsp_shown_level !== want.level ||
                rsp_alarms_enabled !== want.enabled) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT) begin
                  $write("word %0d mismatch: expected sound %0b present %0b alarm %0d",
                         words_seen, want.sound, want.present, want.alarm);
                  $write(" level %0d en %0b", want.level, want.enabled);
                  $display(", got sound %0b present %0b alarm %0d level %0d en %0b",
                           rsp_sound_on, rsp_alarm_present, rsp_shown_alarm,
                           rsp_shown_level, rsp_alarms_enabled);
               end
            end
         end
         words_seen++;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_register_extremes();
      test_priority_choice();
      test_pattern_timing();
      test_output_hold_off();
      test_input_drain_pause();
      test_random_phases();
      wait_idle(SETTLE_CYCLES);
      if (fail_count == 0 && annunciation_q.size() == 0) begin
         $display("** alarm_priority_annunciator: PASSED **");
      end else begin
         $display("** alarm_priority_annunciator: FAILED **");
      end
      $finish;
   end

endmodule
